FILE: hw/rtl/hsv_to_rgb_converter_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the HSV to RGB converter.
// Both macros expect signals named clk and arst_n in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_TOP_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HSV_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hsv2rgb: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define HSV_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hsv2rgb: assertion failed");

`endif

FILE: hw/rtl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Types and constants shared by the HSV to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

	// Hue sectors of 60 degrees each, named by the colours they run between
	typedef logic [2:0] sector_t;
	localparam sector_t SEC_RED_YEL = 3'd0;
	localparam sector_t SEC_YEL_GRN = 3'd1;
	localparam sector_t SEC_GRN_CYN = 3'd2;
	localparam sector_t SEC_CYN_BLU = 3'd3;
	localparam sector_t SEC_BLU_MAG = 3'd4;
	localparam sector_t SEC_MAG_RED = 3'd5;

	// Unit-range level, 256 = 1.0
	typedef logic [8:0] level_t;
	localparam level_t LEVEL_ONE = 9'd256;

	// Hue units per sector (60 degrees in 1/16 degree)
	localparam logic [9:0] HUE_SECTOR = 10'd960;

	// Six full turns, added to make any 16-bit hue non-negative
	localparam logic signed [17:0] HUE_BIAS = 18'sd34560;

	// floor(t/15) = (t * RECIP_15) >> 16 for t below 4096
	localparam logic [12:0] RECIP_15 = 13'd4370;

	// floor(q/6) = (q * RECIP_6) >> 8 for q below 128
	localparam logic [5:0] RECIP_6 = 6'd43;

	// Position on the colour wheel: sector and offset inside it
	typedef struct packed {
		sector_t    sector;
		logic [9:0] f;
	} hue_pos_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hsv2rgb_hue_split.sv
// ----------------------------------------------------------------------------
// hsv2rgb_hue_split
// Two-stage hue wrap: splits a signed hue into sector and offset (mod 5760).
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_hue_split (
	input  wire                     clk,
	input  wire                     adv,
	input  wire logic signed [15:0] hue,
	output hsv2rgb_pkg::hue_pos_t   pos_s2
);
	import hsv2rgb_pkg::*;

	logic [16:0] u_c;
	logic [10:0] t_c;
	logic [23:0] qprod_c;
	logic [16:0] u_s1;
	logic [6:0]  q_s1;
	logic [16:0] q960_c;
	logic [16:0] f_c;
	logic [11:0] q6prod_c;
	logic [3:0]  q6_c;
	logic [6:0]  sec_c;

	// Stage 1: bias to non-negative, quotient by 960 via shift and reciprocal
	assign u_c     = 17'(18'($signed({{2{hue[15]}}, hue})) + HUE_BIAS);
	assign t_c     = u_c[16:6];
	assign qprod_c = 24'(t_c) * 24'(RECIP_15);

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1 <= u_c;
			q_s1 <= qprod_c[22:16];
		end
	end

	// Stage 2: remainder gives the offset, quotient mod 6 gives the sector
	assign q960_c   = {q_s1, 10'b0} - {4'b0, q_s1, 6'b0};
	assign f_c      = u_s1 - q960_c;
	assign q6prod_c = 12'(q_s1) * 12'(RECIP_6);
	assign q6_c     = q6prod_c[11:8];
	assign sec_c    = q_s1 - ({1'b0, q6_c, 2'b0} + {2'b0, q6_c, 1'b0});

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s2.f      <= f_c[9:0];
			pos_s2.sector <= sec_c[2:0];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/hsv_to_rgb_converter_top.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top: fixed-point HSV to 8-bit RGB colour converter.
// One beat per cycle while the output register is empty or its beat is taken.
// The whole pipeline advances together and freezes while the output is held.
// Reset (arst_n, async) clears all stage valid bits; data registers keep junk.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_top (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     hsv_valid,
	output logic                    hsv_ready,
	input  wire logic signed [15:0] hue,
	input  wire logic signed [9:0]  saturation,
	input  wire logic signed [9:0]  brightness,
	output logic                    rgb_valid,
	input  wire                     rgb_ready,
	output logic [7:0]              red,
	output logic [7:0]              green,
	output logic [7:0]              blue
);
	import hsv2rgb_pkg::*;

`include "hsv_to_rgb_converter_top_assert.svh"

	// Pipeline control: one shared enable. Advance whenever the output
	// register is empty or its beat is being taken this cycle.
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;

	assign adv       = !rgb_valid || rgb_ready;
	assign hsv_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			rgb_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= hsv_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			rgb_valid <= v_s4;
		end
	end

	// Hue path: stages 1 and 2 live in the hue splitter
	hue_pos_t pos_s2;

	hsv2rgb_hue_split u_hue (
		.clk    (clk),
		.adv    (adv),
		.hue    (hue),
		.pos_s2 (pos_s2)
	);

	// Stage 1: clamp saturation and brightness onto 0..256
	level_t s_c, v_c;
	level_t s_s1, v_s1_lvl;

	always_comb begin
		if (saturation[9])
			s_c = '0;
		else if (saturation > $signed({1'b0, LEVEL_ONE}))
			s_c = LEVEL_ONE;
		else
			s_c = saturation[8:0];

		if (brightness[9])
			v_c = '0;
		else if (brightness > $signed({1'b0, LEVEL_ONE}))
			v_c = LEVEL_ONE;
		else
			v_c = brightness[8:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s1     <= s_c;
			v_s1_lvl <= v_c;
		end
	end

	// Stage 2: product v*s (at most 65536, so 17 bits)
	logic [16:0] vs_s2;
	level_t      v_s2_lvl;

	always_ff @(posedge clk) begin
		if (adv) begin
			vs_s2    <= 17'(v_s1_lvl) * 17'(s_s1);
			v_s2_lvl <= v_s1_lvl;
		end
	end

	// Stage 3: chroma, offset m, and the numerator of x.
	// Odd sectors run downhill, so mirror the offset there.
	level_t      c_c, m_c;
	logic [9:0]  fsel_c;
	logic [17:0] num_s3;
	level_t      c_s3, m_s3;
	sector_t     sec_s3;

	assign c_c    = vs_s2[16:8];
	assign m_c    = v_s2_lvl - c_c;
	assign fsel_c = pos_s2.sector[0] ? (HUE_SECTOR - pos_s2.f) : pos_s2.f;

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s3 <= 18'(c_c) * 18'(fsel_c);
			c_s3   <= c_c;
			m_s3   <= m_c;
			sec_s3 <= pos_s2.sector;
		end
	end

	// Stage 4: x = floor(num / 960) as (num >> 6) / 15 by reciprocal
	logic [11:0] n2_c;
	logic [24:0] xprod_c;
	level_t      x_s4, c_s4, m_s4;
	sector_t     sec_s4;

	assign n2_c    = num_s3[17:6];
	assign xprod_c = 25'(n2_c) * 25'(RECIP_15);

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s4   <= xprod_c[24:16];
			c_s4   <= c_s3;
			m_s4   <= m_s3;
			sec_s4 <= sec_s3;
		end
	end

	// Stage 5: place c, x and zero on the channels, add m, scale to 8 bits.
	// floor(l*255/256) for l in 0..256 is l-1, except that zero stays zero.
	level_t rp_c, gp_c, bp_c;
	level_t rl_c, gl_c, bl_c;

	always_comb begin
		case (sec_s4)
			SEC_RED_YEL: begin rp_c = c_s4; gp_c = x_s4; bp_c = '0;   end
			SEC_YEL_GRN: begin rp_c = x_s4; gp_c = c_s4; bp_c = '0;   end
			SEC_GRN_CYN: begin rp_c = '0;   gp_c = c_s4; bp_c = x_s4; end
			SEC_CYN_BLU: begin rp_c = '0;   gp_c = x_s4; bp_c = c_s4; end
			SEC_BLU_MAG: begin rp_c = x_s4; gp_c = '0;   bp_c = c_s4; end
			default:     begin rp_c = c_s4; gp_c = '0;   bp_c = x_s4; end
		endcase
	end

	assign rl_c = rp_c + m_s4;
	assign gl_c = gp_c + m_s4;
	assign bl_c = bp_c + m_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			red   <= 8'(rl_c - 9'(rl_c != '0));
			green <= 8'(gl_c - 9'(gl_c != '0));
			blue  <= 8'(bl_c - 9'(bl_c != '0));
		end
	end

	// Checks
	`HSV_ASSERT_NOW(a_sector_range, v_s2, pos_s2.sector <= SEC_MAG_RED)
	`HSV_ASSERT_NOW(a_offset_range, v_s2, pos_s2.f < HUE_SECTOR)
	`HSV_ASSERT_NOW(a_level_sum, v_s3, ({1'b0, c_s3} + {1'b0, m_s3}) <= {1'b0, LEVEL_ONE})
	`HSV_ASSERT_NOW(a_x_le_c, v_s4, x_s4 <= c_s4)
	`HSV_ASSERT_NEXT(a_freeze, !adv, $stable({v_s1, v_s2, v_s3, v_s4}))

endmodule

`default_nettype wire

FILE: sim/hsv_to_rgb_converter_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top_test: HSV to RGB converter testbench
// Drives HSV beats through the valid/ready input and predicts each RGB beat
// in fixed point. Every output beat is compared channel by channel with the
// oldest prediction. Random bursts, receiver stall patterns, a long output
// hold-off and a full drain exercise the pipeline's flow control.
// ----------------------------------------------------------------------------

module hsv_to_rgb_converter_top_test;

	import hsv2rgb_pkg::*;

	// One full turn of the wheel in hue units, six sectors of 960
	localparam int HUE_TURN      = 6 * int'(HUE_SECTOR);
	// Give up after this many cycles in which no beat moves on either side
	localparam int STALL_LIMIT   = 3000;
	// Length of the forced output hold-off, in cycles
	localparam int HOLD_CYCLES   = 300;
	// Settling time after the last result, in cycles
	localparam int TAIL_CYCLES   = 20;
	// Cap on printed mismatch lines, all of them are still counted
	localparam int REPORT_CAP    = 100;

	// One predicted colour, with the input that gave it for reporting
	typedef struct {
		logic signed [15:0] hue;
		logic signed [9:0]  sat;
		logic signed [9:0]  val;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
	} colour_beat_t;

	// Receiver stall patterns
	typedef enum int {
		RX_ALWAYS,
		RX_COIN,
		RX_MOSTLY,
		RX_PERIODIC,
		RX_SPARSE
	} stall_mode_e;

	// ------------------------------------------------------------------------
	// Colour scoreboard: predicts RGB from each accepted HSV beat and checks
	// output beats in order against the oldest prediction.
	// ------------------------------------------------------------------------
	class colour_scoreboard;
		colour_beat_t pending_rgb[$];
		int           colours_in;
		int           colours_out;
		int           mismatches;
		int           sector_hits[6];

		function int clamp_level(logic signed [9:0] raw);
			int lvl;
			lvl = int'(raw);
			if (lvl < 0)
				lvl = 0;
			else if (lvl > int'(LEVEL_ONE))
				lvl = int'(LEVEL_ONE);
			return lvl;
		endfunction

		function colour_beat_t predict_rgb(logic signed [15:0] h, logic signed [9:0] s_raw,
				logic signed [9:0] v_raw);
			colour_beat_t beat;
			int wheel, s, v, chroma, offset, sec, pos, second;
			int rp, gp, bp;
			beat.hue = h;
			beat.sat = s_raw;
			beat.val = v_raw;
			// wrap hue onto one turn, moving a negative truncated remainder up by a turn
			wheel = int'(h) % HUE_TURN;
			if (wheel < 0)
				wheel += HUE_TURN;
			s = clamp_level(s_raw);
			v = clamp_level(v_raw);
			chroma = (v * s) >>> 8;
			offset = v - chroma;
			sec = wheel / int'(HUE_SECTOR);
			pos = wheel % int'(HUE_SECTOR);
			if (sec % 2 == 0)
				second = (chroma * pos) / int'(HUE_SECTOR);
			else
				second = (chroma * (int'(HUE_SECTOR) - pos)) / int'(HUE_SECTOR);
			sector_hits[sec]++;
			case (sector_t'(sec))
				SEC_RED_YEL: begin rp = chroma; gp = second; bp = 0;      end
				SEC_YEL_GRN: begin rp = second; gp = chroma; bp = 0;      end
				SEC_GRN_CYN: begin rp = 0;      gp = chroma; bp = second; end
				SEC_CYN_BLU: begin rp = 0;      gp = second; bp = chroma; end
				SEC_BLU_MAG: begin rp = second; gp = 0;      bp = chroma; end
				default: begin     rp = chroma; gp = 0;      bp = second; end
			endcase
			beat.red   = 8'(((rp + offset) * 255) / 256);
			beat.green = 8'(((gp + offset) * 255) / 256);
			beat.blue  = 8'(((bp + offset) * 255) / 256);
			return beat;
		endfunction

		function void note_input(logic signed [15:0] h, logic signed [9:0] s,
				logic signed [9:0] v);
			pending_rgb.push_back(predict_rgb(h, s, v));
			colours_in++;
		endfunction

		function void flag_field(string chan, colour_beat_t want, logic [7:0] got_val,
				logic [7:0] want_val);
			mismatches++;
			if (mismatches <= REPORT_CAP)
				$display("%0t: %s mismatch for hsv (%0d,%0d,%0d): expected %0d, got %0d",
					$time, chan, want.hue, want.sat, want.val, want_val, got_val);
			else if (mismatches == REPORT_CAP + 1)
				$display("%0t: further mismatches counted but not shown", $time);
		endfunction

		function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			colour_beat_t want;
			colours_out++;
			if (pending_rgb.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected rgb beat: expected none, got (%0d,%0d,%0d)",
					$time, r, g, b);
				return;
			end
			want = pending_rgb.pop_front();
			if (r !== want.red)
				flag_field("red", want, r, want.red);
			if (g !== want.green)
				flag_field("green", want, g, want.green);
			if (b !== want.blue)
				flag_field("blue", want, b, want.blue);
		endfunction

		function int pending();
			return pending_rgb.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and block signals; every input starts at a known value
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               hsv_valid = 1'b0;
	logic               hsv_ready;
	logic signed [15:0] hue = '0;
	logic signed [9:0]  saturation = '0;
	logic signed [9:0]  brightness = '0;
	logic               rgb_valid;
	logic               rgb_ready = 1'b0;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;

	colour_scoreboard sb = new();

	// Hold-off requests from the stimulus side, served by the receiver
	int hold_ticket = 0;
	int holds_done = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	hsv_to_rgb_converter_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.hsv_valid  (hsv_valid),
		.hsv_ready  (hsv_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.rgb_valid  (rgb_valid),
		.rgb_ready  (rgb_ready),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	// ------------------------------------------------------------------------
	// Receiver: check each output beat, then pick the next ready value. The
	// stall pattern changes every so often; a hold-off request drops ready
	// for a long stretch so the pipeline fills and pushes back on the input.
	// ------------------------------------------------------------------------
	stall_mode_e rx_mode = RX_ALWAYS;
	int          rx_mode_left = 0;
	int          rx_hold_left = 0;
	int          rx_hold_seen = 0;
	int          rx_phase = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgb_ready <= 1'b0;
		end else begin
			// values sampled here are the ones that held at this edge
			if (rgb_valid && rgb_ready)
				sb.check_result(red, green, blue);

			rx_phase++;
			if (rx_mode_left == 0) begin
				rx_mode = stall_mode_e'($urandom_range(RX_ALWAYS, RX_SPARSE));
				rx_mode_left = $urandom_range(16, 120);
			end else begin
				rx_mode_left--;
			end

			if (rx_hold_seen != hold_ticket) begin
				rx_hold_seen = hold_ticket;
				rx_hold_left = HOLD_CYCLES;
			end

			if (rx_hold_left > 0) begin
				rx_hold_left--;
				if (rx_hold_left == 0)
					holds_done++;
				rgb_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS:   rgb_ready <= 1'b1;
					RX_COIN:     rgb_ready <= 1'($urandom_range(0, 1));
					RX_MOSTLY:   rgb_ready <= ($urandom_range(0, 9) != 0);
					RX_PERIODIC: rgb_ready <= (rx_phase % 3 != 0);
					default:     rgb_ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: end the run if nothing moves for too long
	// ------------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((hsv_valid && hsv_ready) || (rgb_valid && rgb_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles, %0d results outstanding",
					$time, STALL_LIMIT, sb.pending());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender tasks
	// ------------------------------------------------------------------------

	// Offer one beat and hold it until accepted; valid stays high afterwards
	// so a following beat can go out back to back.
	task automatic send_colour(logic signed [15:0] h, logic signed [9:0] s,
			logic signed [9:0] v);
		hsv_valid  <= 1'b1;
		hue        <= h;
		saturation <= s;
		brightness <= v;
		do
			@(posedge clk);
		while (!hsv_ready);
		sb.note_input(h, s, v);
	endtask

	// Mostly in range, some around the clamp edges, some anywhere in 10 bits
	function automatic logic signed [9:0] pick_level();
		case ($urandom_range(0, 9))
			7:       return 10'($urandom_range(254, 258));
			8, 9:    return 10'($urandom);
			default: return 10'($urandom_range(0, 256));
		endcase
	endfunction

	task automatic send_random_colour();
		int h;
		case ($urandom_range(0, 3))
			0: h = int'($urandom);
			1: h = int'($urandom_range(0, HUE_TURN - 1));
			// land on or next to a sector boundary
			2: h = int'($urandom_range(0, 6)) * int'(HUE_SECTOR) + int'($urandom_range(0, 4)) - 2;
			// a point on the wheel shifted by whole turns either way
			default: h = int'($urandom_range(0, HUE_TURN - 1))
				+ HUE_TURN * (int'($urandom_range(0, 10)) - 5);
		endcase
		send_colour(16'(h), pick_level(), pick_level());
	endtask

	// Random bursts separated by random gaps, with the odd long burst
	task automatic bursty_traffic(int count);
		int left, burst, gap;
		left = count;
		while (left > 0) begin
			burst = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 48);
			for (int k = 0; k < burst && left > 0; k++) begin
				send_random_colour();
				left--;
			end
			gap = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 3);
			if (gap > 0) begin
				hsv_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Drop valid and wait for every predicted colour to come back
	task automatic drain_results();
		hsv_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Directed colours: sector starts and middles, hue wrap extremes, and
	// saturation and brightness below zero, above one and at the 10-bit ends
	// ------------------------------------------------------------------------
	int dir_hue[25] = '{0, 960, 1920, 2880, 3840, 4800, 480, 1440, 2400, 3360, 4320, 5280,
		5759, 5760, -1, -32768, 32767, 100, 100, 100, 100, 700, 700, 700, 959};
	int dir_sat[25] = '{256, 256, 256, 256, 256, 256, 256, 200, 128, 256, 255, 100,
		256, 256, 256, 256, 256, -512, -1, 511, 257, 256, 256, 0, 256};
	int dir_val[25] = '{256, 256, 256, 256, 256, 256, 256, 200, 256, 128, 255, 220,
		256, 256, 256, 256, 256, 256, 256, 256, 256, -512, 511, 0, 256};

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 25; i++)
			send_colour(16'(dir_hue[i]), 10'(dir_sat[i]), 10'(dir_val[i]));
		drain_results();

		bursty_traffic(400);

		// stall the output for a long stretch while beats keep coming
		hold_ticket <= hold_ticket + 1;
		for (int i = 0; i < 80; i++)
			send_random_colour();

		bursty_traffic(400);

		// pause the input until the pipeline is empty, then carry on
		drain_results();
		bursty_traffic(445);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d colours, checked %0d results; hue sectors hit %0d/%0d/%0d/%0d/%0d/%0d",
			sb.colours_in, sb.colours_out, sb.sector_hits[0], sb.sector_hits[1],
			sb.sector_hits[2], sb.sector_hits[3], sb.sector_hits[4], sb.sector_hits[5]);
		$display("Output hold-offs served: %0d; mismatches: %0d; left over: %0d",
			holds_done, sb.mismatches, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
